// ----- rtl/bwrc_pkg.sv -----
// bwrc_pkg: shared types, codes and constants of the window refcount cache
// used by every rtl file of the block; depends on nothing
`timescale 1ns / 1ps

package bwrc_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int REF_BITS_DEF      = 16;
    localparam int ADDR_W            = 48;
    localparam int CFG_W             = 48;
    localparam int CFG_IDX_W         = 3;

    localparam logic [2:0] CFG_SCALE  = 3'd0;
    localparam logic [2:0] CFG_OFFSET = 3'd1;
    localparam logic [2:0] CFG_MOD    = 3'd2;
    localparam logic [2:0] CFG_SUBB   = 3'd3;
    localparam logic [2:0] CFG_UNIT   = 3'd4;
    localparam logic [2:0] CFG_PARK   = 3'd5;

    typedef enum logic [1:0] {
        REQ_ACCESS  = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_FLUSH   = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_HIT     = 4'd0,
        ST_MISS    = 4'd1,
        ST_KEPT    = 4'd2,
        ST_PARKED  = 4'd3,
        ST_EVICTED = 4'd4,
        ST_FLUSHED = 4'd5,
        ST_EMPTY   = 4'd6,
        ST_FULL    = 4'd7,
        ST_UNKNOWN = 4'd8,
        ST_CNTERR  = 4'd9
    } status_t;

    // classified request passed from front to back
    typedef struct packed {
        req_t              kind;
        logic [ADDR_W-1:0] win;
        logic [31:0]       boff;
    } job_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [3:0]  slot;
        logic [47:0] win;
        logic [31:0] boff;
        logic [63:0] mpos;
        logic        last;
    } res_t;

    typedef enum logic [1:0] {
        FS_IDLE = 2'd0,
        FS_MUL  = 2'd1,
        FS_DIV  = 2'd2,
        FS_OUT  = 2'd3
    } fstate_t;

    typedef enum logic [3:0] {
        BS_IDLE   = 4'd0,
        BS_SEARCH = 4'd1,
        BS_DECIDE = 4'd2,
        BS_PQSCAN = 4'd3,
        BS_SHIFT  = 4'd4,
        BS_EMIT   = 4'd5,
        BS_MPOS   = 4'd6,
        BS_FLUSH  = 4'd7,
        BS_EVICT2 = 4'd8
    } bstate_t;

endpackage

// ----- rtl/bwrc_front.sv -----
// bwrc_front: address scaling and window split of every request, whatever its kind
// uses bwrc_pkg; feeds the job queue towards bwrc_back
`timescale 1ns / 1ps

module bwrc_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   in_type,
    input  logic [47:0]                  in_block,
    input  logic [12:0]                  scale_factor,
    input  logic [47:0]                  start_offset,
    input  logic [16:0]                  window_modulus,
    input  logic [16:0]                  sub_block_bytes,
    output logic                         job_valid,
    input  logic                         job_ready,
    output bwrc_pkg::job_t               job
);

    bwrc_pkg::fstate_t state_reg, state_next;
    logic [1:0]  type_reg;
    logic [47:0] block_reg;
    logic [47:0] addr_reg;
    logic [47:0] rem_reg;
    logic [16:0] mod_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] boff_reg;
    logic [60:0] prod;
    logic [17:0] trial;
    logic [48:0] shifted;
    logic        do_split;

    assign prod     = block_reg * scale_factor;
    assign do_split = (window_modulus > 17'd1);
    assign in_ready = (state_reg == bwrc_pkg::FS_IDLE);

    // restoring division, one quotient bit per cycle; rem_reg holds partial remainder
    assign shifted = {rem_reg, addr_reg[47]};
    assign trial   = shifted[17:0] - {1'b0, mod_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bwrc_pkg::FS_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bwrc_pkg::FS_MUL;
                end
            end
            bwrc_pkg::FS_MUL:
            begin
                state_next = bwrc_pkg::FS_DIV;
            end
            bwrc_pkg::FS_DIV:
            begin
                if (cnt_reg == 6'd48)
                begin
                    state_next = bwrc_pkg::FS_OUT;
                end
            end
            bwrc_pkg::FS_OUT:
            begin
                if (job_ready)
                begin
                    state_next = bwrc_pkg::FS_IDLE;
                end
            end
            default: state_next = bwrc_pkg::FS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bwrc_pkg::FS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            bwrc_pkg::FS_IDLE:
            begin
                type_reg  <= in_type;
                block_reg <= in_block;
            end
            bwrc_pkg::FS_MUL:
            begin
                addr_reg <= prod[47:0] + start_offset;
                block_reg <= prod[47:0] + start_offset;
                rem_reg  <= '0;
                mod_reg  <= do_split ? window_modulus : 17'd1;
                cnt_reg  <= '0;
            end
            bwrc_pkg::FS_DIV:
            begin
                if (cnt_reg != 6'd48)
                begin
                    addr_reg <= {addr_reg[46:0], 1'b0};
                    if (!trial[17])
                    begin
                        rem_reg <= {30'd0, trial};
                    end
                    else
                    begin
                        rem_reg <= {30'd0, shifted[17:0]};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                end
                else
                begin
                    boff_reg <= 32'(rem_reg[16:0] * sub_block_bytes);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign job_valid = (state_reg == bwrc_pkg::FS_OUT);
    assign job.kind  = bwrc_pkg::req_t'(type_reg);
    assign job.win   = block_reg - rem_reg;
    assign job.boff  = boff_reg;

endmodule

// ----- rtl/bwrc_queue.sv -----
// bwrc_queue: small two-entry fifo of classified jobs between front and back
// uses bwrc_pkg for the job type
`timescale 1ns / 1ps

module bwrc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  bwrc_pkg::job_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output bwrc_pkg::job_t rd_data
);

    bwrc_pkg::job_t mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;
    logic       do_wr;
    logic       do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (do_rd)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/bwrc_back.sv -----
// bwrc_back: slot table, reference counts and park queue; produces results
// uses bwrc_pkg; takes jobs from bwrc_queue, writes results to an output fifo
`timescale 1ns / 1ps

module bwrc_back #(
    parameter int TABLE_ENTRIES = bwrc_pkg::TABLE_ENTRIES_DEF,
    parameter int REF_BITS      = bwrc_pkg::REF_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    output logic                  job_ready,
    input  bwrc_pkg::job_t        job,
    input  logic [16:0]           unit_bytes,
    input  logic [4:0]            park_limit,
    output logic                  res_valid,
    input  logic                  res_ready,
    output bwrc_pkg::res_t        res
);

    localparam int SW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [REF_BITS-1:0] MAXREF = '1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(TABLE_ENTRIES - 1);

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [47:0]              win_reg  [TABLE_ENTRIES];
    logic [REF_BITS-1:0]      refs_reg [TABLE_ENTRIES];
    logic [SW-1:0]            pq_reg   [TABLE_ENTRIES];
    logic [CW-1:0]            pcnt_reg;

    bwrc_pkg::bstate_t state_reg, state_next;
    bwrc_pkg::job_t    job_reg;
    logic [SW-1:0]     idx_reg;
    logic              found_reg;
    logic [SW-1:0]     hit_reg;
    logic              free_ok_reg;
    logic [SW-1:0]     free_reg;
    logic [CW-1:0]     pos_reg;
    bwrc_pkg::res_t    r0_reg;
    logic              two_reg;
    bwrc_pkg::res_t    r1_reg;
    logic              miss_reg;
    logic [SW-1:0]     evslot;
    logic [CW-1:0]     pq_pos;

    assign evslot    = pq_reg[0];
    assign job_ready = (state_reg == bwrc_pkg::BS_IDLE);
    assign res_valid = (state_reg == bwrc_pkg::BS_EMIT) || (state_reg == bwrc_pkg::BS_FLUSH
                       && pcnt_reg != '0) || (state_reg == bwrc_pkg::BS_EVICT2);
    assign res = (state_reg == bwrc_pkg::BS_EMIT) ? r0_reg :
                 (state_reg == bwrc_pkg::BS_EVICT2) ? r1_reg :
                 '{status: bwrc_pkg::ST_FLUSHED, slot: 4'(evslot), win: win_reg[evslot],
                   boff: 32'd0, mpos: 64'd0, last: (pcnt_reg == CW'(1))};

    // position of the hit slot in the park queue, all ones when absent
    always_comb
    begin
        pq_pos = '1;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (CW'(i) < pcnt_reg && pq_reg[i] == hit_reg)
            begin
                pq_pos = CW'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bwrc_pkg::BS_IDLE:
            begin
                if (job_valid)
                begin
                    if (job.kind == bwrc_pkg::REQ_FLUSH)
                    begin
                        state_next = bwrc_pkg::BS_FLUSH;
                    end
                    else if (job.kind != bwrc_pkg::REQ_NONE)
                    begin
                        state_next = bwrc_pkg::BS_SEARCH;
                    end
                end
            end
            bwrc_pkg::BS_SEARCH:
            begin
                if (idx_reg == LAST_SLOT)
                begin
                    state_next = bwrc_pkg::BS_DECIDE;
                end
            end
            bwrc_pkg::BS_DECIDE:  state_next = bwrc_pkg::BS_PQSCAN;
            bwrc_pkg::BS_PQSCAN:  state_next = bwrc_pkg::BS_SHIFT;
            bwrc_pkg::BS_SHIFT:
            begin
                state_next = miss_reg ? bwrc_pkg::BS_MPOS : bwrc_pkg::BS_EMIT;
            end
            bwrc_pkg::BS_MPOS:    state_next = bwrc_pkg::BS_EMIT;
            bwrc_pkg::BS_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = two_reg ? bwrc_pkg::BS_EVICT2 : bwrc_pkg::BS_IDLE;
                end
            end
            bwrc_pkg::BS_EVICT2:
            begin
                if (res_ready)
                begin
                    state_next = bwrc_pkg::BS_IDLE;
                end
            end
            bwrc_pkg::BS_FLUSH:
            begin
                if (pcnt_reg == '0)
                begin
                    state_next = bwrc_pkg::BS_EMIT;
                end
                else if (res_ready && pcnt_reg == CW'(1))
                begin
                    state_next = bwrc_pkg::BS_IDLE;
                end
            end
            default: state_next = bwrc_pkg::BS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bwrc_pkg::BS_IDLE;
            valid_reg <= '0;
            pcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                bwrc_pkg::BS_DECIDE:
                begin
                    // evict on a miss with full table and parked windows
                    if (job_reg.kind == bwrc_pkg::REQ_ACCESS && !found_reg && !free_ok_reg
                        && pcnt_reg != '0)
                    begin
                        valid_reg[evslot] <= 1'b0;
                    end
                end
                bwrc_pkg::BS_PQSCAN:
                begin
                    if (miss_reg)
                    begin
                        valid_reg[free_reg] <= 1'b1;
                    end
                end
                bwrc_pkg::BS_SHIFT:
                begin
                    if (pos_reg < pcnt_reg)
                    begin
                        pcnt_reg <= pcnt_reg - CW'(1);
                    end
                    else if (two_reg || (r0_reg.status == bwrc_pkg::ST_PARKED))
                    begin
                        if (pcnt_reg < CW'(TABLE_ENTRIES))
                        begin
                            pcnt_reg <= pcnt_reg + CW'(1);
                        end
                    end
                end
                bwrc_pkg::BS_EVICT2:
                begin
                    if (res_ready && !miss_reg)
                    begin
                        valid_reg[evslot] <= 1'b0;
                        pcnt_reg <= pcnt_reg - CW'(1);
                    end
                end
                bwrc_pkg::BS_FLUSH:
                begin
                    if (res_ready && pcnt_reg != '0)
                    begin
                        valid_reg[evslot] <= 1'b0;
                        pcnt_reg <= pcnt_reg - CW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            bwrc_pkg::BS_IDLE:
            begin
                job_reg     <= job;
                idx_reg     <= '0;
                found_reg   <= 1'b0;
                free_ok_reg <= 1'b0;
                two_reg     <= 1'b0;
                miss_reg    <= 1'b0;
                pos_reg     <= '1;
                r0_reg      <= '{status: bwrc_pkg::ST_EMPTY, slot: 4'd0, win: 48'd0,
                                 boff: 32'd0, mpos: 64'd0, last: 1'b1};
            end
            bwrc_pkg::BS_SEARCH:
            begin
                idx_reg <= idx_reg + SW'(1);
                if (valid_reg[idx_reg] && win_reg[idx_reg] == job_reg.win && !found_reg)
                begin
                    found_reg <= 1'b1;
                    hit_reg   <= idx_reg;
                end
                if (!valid_reg[idx_reg] && !free_ok_reg)
                begin
                    free_ok_reg <= 1'b1;
                    free_reg    <= idx_reg;
                end
            end
            bwrc_pkg::BS_DECIDE:
            begin
                r0_reg.win  <= job_reg.win;
                r0_reg.boff <= job_reg.boff;
                r0_reg.mpos <= 64'd0;
                r0_reg.last <= 1'b1;
                r0_reg.slot <= found_reg ? 4'(hit_reg) : 4'd0;
                if (job_reg.kind == bwrc_pkg::REQ_ACCESS)
                begin
                    if (found_reg)
                    begin
                        if (refs_reg[hit_reg] == MAXREF)
                        begin
                            r0_reg.status <= bwrc_pkg::ST_CNTERR;
                        end
                        else
                        begin
                            r0_reg.status <= bwrc_pkg::ST_HIT;
                            refs_reg[hit_reg] <= refs_reg[hit_reg] + REF_BITS'(1);
                            if (refs_reg[hit_reg] == '0)
                            begin
                                pos_reg <= '0;
                            end
                        end
                    end
                    else if (free_ok_reg)
                    begin
                        miss_reg <= 1'b1;
                    end
                    else if (pcnt_reg == '0)
                    begin
                        r0_reg.status <= bwrc_pkg::ST_FULL;
                    end
                    else
                    begin
                        // emit eviction first, then the miss as second result
                        miss_reg <= 1'b1;
                        free_reg <= evslot;
                        two_reg  <= 1'b1;
                        pos_reg  <= '0;
                    end
                end
                else
                begin
                    if (!found_reg)
                    begin
                        r0_reg.status <= bwrc_pkg::ST_UNKNOWN;
                    end
                    else if (refs_reg[hit_reg] == '0)
                    begin
                        r0_reg.status <= bwrc_pkg::ST_CNTERR;
                    end
                    else
                    begin
                        refs_reg[hit_reg] <= refs_reg[hit_reg] - REF_BITS'(1);
                        if (refs_reg[hit_reg] == REF_BITS'(1))
                        begin
                            r0_reg.status <= bwrc_pkg::ST_PARKED;
                        end
                        else
                        begin
                            r0_reg.status <= bwrc_pkg::ST_KEPT;
                        end
                    end
                end
            end
            bwrc_pkg::BS_PQSCAN:
            begin
                if (miss_reg)
                begin
                    win_reg[free_reg]  <= job_reg.win;
                    refs_reg[free_reg] <= REF_BITS'(1);
                    if (two_reg)
                    begin
                        r0_reg <= '{status: bwrc_pkg::ST_EVICTED, slot: 4'(evslot),
                                    win: win_reg[evslot], boff: 32'd0, mpos: 64'd0,
                                    last: 1'b0};
                        r1_reg <= '{status: bwrc_pkg::ST_MISS, slot: 4'(free_reg),
                                    win: job_reg.win, boff: job_reg.boff, mpos: 64'd0,
                                    last: 1'b1};
                    end
                    else
                    begin
                        r0_reg.status <= bwrc_pkg::ST_MISS;
                        r0_reg.slot   <= 4'(free_reg);
                    end
                end
                else if (pos_reg == '0 && !two_reg)
                begin
                    // locate the hit slot in the park queue
                    pos_reg <= pq_pos;
                end
            end
            bwrc_pkg::BS_SHIFT:
            begin
                if (pos_reg < pcnt_reg)
                begin
                    for (int i = 0; i < TABLE_ENTRIES - 1; i++)
                    begin
                        if (CW'(i) >= pos_reg)
                        begin
                            pq_reg[i] <= pq_reg[i + 1];
                        end
                    end
                end
                else if (r0_reg.status == bwrc_pkg::ST_PARKED)
                begin
                    if (pcnt_reg < CW'(TABLE_ENTRIES))
                    begin
                        pq_reg[pcnt_reg[SW-1:0]] <= hit_reg;
                    end
                    if ({1'b0, pcnt_reg} + (CW+1)'(pcnt_reg < CW'(TABLE_ENTRIES))
                        > (CW+1)'(park_limit))
                    begin
                        two_reg     <= 1'b1;
                        r0_reg.last <= 1'b0;
                    end
                end
            end
            bwrc_pkg::BS_MPOS:
            begin
                if (two_reg)
                begin
                    r1_reg.mpos <= 64'(job_reg.win * unit_bytes);
                end
                else
                begin
                    r0_reg.mpos <= 64'(job_reg.win * unit_bytes);
                end
            end
            bwrc_pkg::BS_EMIT:
            begin
                // a release that parks then evicts the oldest
                if (res_ready && two_reg && !miss_reg)
                begin
                    r1_reg <= '{status: bwrc_pkg::ST_EVICTED, slot: 4'(evslot),
                                win: win_reg[evslot], boff: 32'd0, mpos: 64'd0,
                                last: 1'b1};
                end
            end
            default:
            begin
            end
        endcase
        if ((state_reg == bwrc_pkg::BS_EVICT2 && !miss_reg) || state_reg == bwrc_pkg::BS_FLUSH)
        begin
            if (res_ready && pcnt_reg != '0)
            begin
                for (int i = 0; i < TABLE_ENTRIES - 1; i++)
                begin
                    pq_reg[i] <= pq_reg[i + 1];
                end
            end
        end
    end

endmodule

// ----- rtl/bwrc_outq.sv -----
// bwrc_outq: two-entry result fifo that drives the result ports
// uses bwrc_pkg for the result type
`timescale 1ns / 1ps

module bwrc_outq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  bwrc_pkg::res_t wr_data,
    output logic           empty,
    input  logic           pop,
    output bwrc_pkg::res_t rd_data
);

    bwrc_pkg::res_t mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;
    logic       do_wr;
    logic       do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign rd_data  = mem_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (do_rd)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/block_window_refcount_cache.sv -----
// block_window_refcount_cache: top level of the window refcount cache
// uses bwrc_pkg, bwrc_front, bwrc_queue, bwrc_back and bwrc_outq
`timescale 1ns / 1ps

// usage:
// requests enter through push/full; a request is taken when push is high and
// full is low. results leave through empty/pop; the oldest result is on the
// result ports while empty is low and is taken when pop is high.
// a request other than none gives one or more results, the final one marked by
// last; flush gives one result for each parked window, or one empty result
// when none is parked. the front scales the address, forms the remainder by
// the window modulus bit by bit (the last step forms the byte offset), then
// outputs the job; it takes no new request until that job is handed on.
// the back takes the job, searches the slots of the table, sixteen by default, one by
// one, updates the park queue in the shift state after the decide and park-queue scan states,
// adds the map position multiply on a miss, then emits. flush retires the
// parked windows oldest first. front and back overlap through a two-entry queue.
// reset empties the table and the park queue and loads register defaults.
// full is high whenever the front is busy; when pop stays low the result fifo
// fills, the back stalls, then the job queue fills and the front holds its job.
// configuration is written through cfg_we/cfg_index/cfg_data; the user must do
// so only while idle, the block itself does not enforce it.

module block_window_refcount_cache #(
    parameter int TABLE_ENTRIES = bwrc_pkg::TABLE_ENTRIES_DEF,
    parameter int REF_BITS      = bwrc_pkg::REF_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [1:0]                     req_type,
    input  logic [47:0]                    block_number,
    output logic                           empty,
    input  logic                           pop,
    output logic [3:0]                     status,
    output logic [3:0]                     slot,
    output logic [47:0]                    window_number,
    output logic [31:0]                    byte_offset,
    output logic [63:0]                    map_position,
    output logic                           last,
    input  logic                           cfg_we,
    input  logic [bwrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bwrc_pkg::CFG_W-1:0]     cfg_data
);

    logic [12:0] scale_reg;
    logic [47:0] offset_reg;
    logic [16:0] mod_reg;
    logic [16:0] subb_reg;
    logic [16:0] unit_reg;
    logic [4:0]  park_reg;
    logic        in_ready;
    logic        fj_valid, fj_ready, bj_valid, bj_ready;
    logic        r_valid, r_ready;
    bwrc_pkg::job_t fjob, bjob;
    bwrc_pkg::res_t rres, ores;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= 13'd1;
            offset_reg <= 48'd0;
            mod_reg    <= 17'd1;
            subb_reg   <= 17'd512;
            unit_reg   <= 17'd512;
            park_reg   <= 5'd8;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bwrc_pkg::CFG_SCALE:  scale_reg  <= cfg_data[12:0];
                bwrc_pkg::CFG_OFFSET: offset_reg <= cfg_data[47:0];
                bwrc_pkg::CFG_MOD:    mod_reg    <= cfg_data[16:0];
                bwrc_pkg::CFG_SUBB:   subb_reg   <= cfg_data[16:0];
                bwrc_pkg::CFG_UNIT:   unit_reg   <= cfg_data[16:0];
                bwrc_pkg::CFG_PARK:   park_reg   <= cfg_data[4:0];
                default:
                begin
                end
            endcase
        end
    end

    assign full = !in_ready;

    bwrc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (push),
        .in_ready        (in_ready),
        .in_type         (req_type),
        .in_block        (block_number),
        .scale_factor    (scale_reg),
        .start_offset    (offset_reg),
        .window_modulus  (mod_reg),
        .sub_block_bytes (subb_reg),
        .job_valid       (fj_valid),
        .job_ready       (fj_ready),
        .job             (fjob)
    );

    bwrc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fj_valid),
        .wr_ready (fj_ready),
        .wr_data  (fjob),
        .rd_valid (bj_valid),
        .rd_ready (bj_ready),
        .rd_data  (bjob)
    );

    bwrc_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .REF_BITS      (REF_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (bj_valid),
        .job_ready  (bj_ready),
        .job        (bjob),
        .unit_bytes (unit_reg),
        .park_limit (park_reg),
        .res_valid  (r_valid),
        .res_ready  (r_ready),
        .res        (rres)
    );

    bwrc_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (r_valid),
        .wr_ready (r_ready),
        .wr_data  (rres),
        .empty    (empty),
        .pop      (pop),
        .rd_data  (ores)
    );

    assign status        = ores.status;
    assign slot          = ores.slot;
    assign window_number = ores.win;
    assign byte_offset   = ores.boff;
    assign map_position  = ores.mpos;
    assign last          = ores.last;

endmodule

// ----- rtl/bwrc_checker.sv -----
// bwrc_checker: port-level assertions of the window refcount cache
// uses bwrc_pkg and the top level ports; bound to block_window_refcount_cache
`timescale 1ns / 1ps

module bwrc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [3:0]  status,
    input logic [63:0] map_position,
    input logic        last
);

    // result held while not taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(status) && $stable(last))
        else $error("result changed while waiting");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> status <= bwrc_pkg::ST_CNTERR)
        else $error("status code out of range");

    a_mpos: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && status != bwrc_pkg::ST_MISS |-> map_position == 64'd0)
        else $error("map position on non-miss");

    a_evlast: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && (status == bwrc_pkg::ST_HIT || status == bwrc_pkg::ST_MISS
        || status == bwrc_pkg::ST_EMPTY) |-> last)
        else $error("final result not marked");

endmodule

bind block_window_refcount_cache bwrc_checker u_bwrc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .status       (status),
    .map_position (map_position),
    .last         (last)
);

// ----- tb/tb.sv -----
// tb: self-checking bench for block_window_refcount_cache
// depends on bwrc_pkg and the block rtl; queue-fed driver, clocked monitor
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic [1:0]  kind;
        logic [47:0] bn;
    } creq_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [3:0]  slot;
        logic [47:0] win;
        logic [31:0] boff;
        logic [63:0] mpos;
        logic        last;
    } cres_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  req_type = bwrc_pkg::REQ_ACCESS;
    logic [47:0] block_number = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [3:0]  status;
    logic [3:0]  slot;
    logic [47:0] window_number;
    logic [31:0] byte_offset;
    logic [63:0] map_position;
    logic        last;
    logic        cfg_we = 1'b0;
    logic [bwrc_pkg::CFG_IDX_W-1:0] cfg_index = bwrc_pkg::CFG_SCALE;
    logic [bwrc_pkg::CFG_W-1:0]     cfg_data = '0;

    block_window_refcount_cache DUT (.*);

    always #5 clk = ~clk;

    // predictor state
    logic [12:0] m_scale;
    logic [47:0] m_offset;
    logic [16:0] m_mod, m_subb, m_unit;
    logic [4:0]  m_park;
    logic        t_valid [16];
    logic [47:0] t_win [16];
    logic [15:0] t_refs [16];
    logic [3:0]  pq [16];
    int          pq_cnt;

    creq_t pending_reqs[$];
    cres_t expected_results[$];
    int    errors = 0;
    int    send_idle = 0;
    int    recv_idle = 0;
    bit    sending = 0;
    longint cycles = 0;

    function automatic void add_res(logic [3:0] st, logic [3:0] sl, logic [47:0] w,
                                    logic [31:0] bo, logic [63:0] mp, logic l);
        cres_t r;
        r = '{st, sl, w, bo, mp, l};
        expected_results.push_back(r);
    endfunction

    function automatic void unpark(int p);
        for (int i = p; i + 1 < pq_cnt; i++)
            pq[i] = pq[i + 1];
        pq_cnt--;
    endfunction

    function automatic void predict_cache(creq_t q);
        logic [47:0] addr, sub, win;
        logic [31:0] bo;
        logic [3:0]  e;
        int s;
        s = -1;
        if (q.kind == bwrc_pkg::REQ_NONE)
            return;
        if (q.kind == bwrc_pkg::REQ_FLUSH) begin
            if (pq_cnt == 0) begin
                add_res(bwrc_pkg::ST_EMPTY, 0, 0, 0, 0, 1'b1);
                return;
            end
            while (pq_cnt > 0) begin
                e = pq[0];
                unpark(0);
                t_valid[e] = 1'b0;
                add_res(bwrc_pkg::ST_FLUSHED, e, t_win[e], 0, 0, pq_cnt == 0);
            end
            return;
        end
        addr = q.bn * m_scale + m_offset;
        sub = (m_mod > 1) ? addr % m_mod : 48'd0;
        win = addr - sub;
        bo = 32'(sub * m_subb);
        for (int i = 0; i < 16; i++)
            if (s < 0 && t_valid[i] && t_win[i] == win)
                s = i;
        if (q.kind == bwrc_pkg::REQ_ACCESS) begin
            if (s >= 0) begin
                if (t_refs[s] == 16'hFFFF) begin
                    add_res(bwrc_pkg::ST_CNTERR, 4'(s), win, bo, 0, 1'b1);
                    return;
                end
                if (t_refs[s] == 0)
                    for (int i = 0; i < pq_cnt; i++)
                        if (pq[i] == 4'(s))
                        begin
                            unpark(i);
                            break;
                        end
                t_refs[s]++;
                add_res(bwrc_pkg::ST_HIT, 4'(s), win, bo, 0, 1'b1);
                return;
            end
            for (int i = 0; i < 16; i++)
                if (s < 0 && !t_valid[i])
                    s = i;
            if (s < 0) begin
                if (pq_cnt == 0) begin
                    add_res(bwrc_pkg::ST_FULL, 0, win, bo, 0, 1'b1);
                    return;
                end
                e = pq[0];
                add_res(bwrc_pkg::ST_EVICTED, e, t_win[e], 0, 0, 1'b0);
                unpark(0);
                t_valid[e] = 1'b0;
                s = int'(e);
            end
            t_valid[s] = 1'b1;
            t_win[s] = win;
            t_refs[s] = 16'd1;
            add_res(bwrc_pkg::ST_MISS, 4'(s), win, bo, 64'(win) * 64'(m_unit), 1'b1);
            return;
        end
        if (s < 0) begin
            add_res(bwrc_pkg::ST_UNKNOWN, 0, win, bo, 0, 1'b1);
            return;
        end
        if (t_refs[s] == 0) begin
            add_res(bwrc_pkg::ST_CNTERR, 4'(s), win, bo, 0, 1'b1);
            return;
        end
        t_refs[s]--;
        if (t_refs[s] != 0) begin
            add_res(bwrc_pkg::ST_KEPT, 4'(s), win, bo, 0, 1'b1);
            return;
        end
        if (pq_cnt < 16)
        begin
            pq[pq_cnt] = 4'(s);
            pq_cnt++;
        end
        if (pq_cnt > m_park) begin
            e = pq[0];
            add_res(bwrc_pkg::ST_PARKED, 4'(s), win, bo, 0, 1'b0);
            add_res(bwrc_pkg::ST_EVICTED, e, t_win[e], 0, 0, 1'b1);
            unpark(0);
            t_valid[e] = 1'b0;
        end
        else
            add_res(bwrc_pkg::ST_PARKED, 4'(s), win, bo, 0, 1'b1);
    endfunction

    // driver
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (push && !full) begin
            predict_cache(pending_reqs.pop_front());
        end
        if (sending && pending_reqs.size() > 0 && ($urandom_range(99) >= send_idle)) begin
            push <= 1'b1;
            req_type <= pending_reqs[0].kind;
            block_number <= pending_reqs[0].bn;
        end
        else if (push && !full)
            push <= 1'b0;
        pop <= ($urandom_range(99) >= recv_idle);
    end

    // monitor
    always @(posedge clk)
    begin
        cres_t x;
        if (rst_n && pop && !empty) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result status %0d", status);
                errors++;
            end
            else begin
                x = expected_results.pop_front();
                if (status !== x.status) begin
                    $error("status exp %0d got %0d", x.status, status); errors++;
                end
                if (slot !== x.slot) begin
                    $error("slot exp %0d got %0d", x.slot, slot); errors++;
                end
                if (window_number !== x.win) begin
                    $error("window_number exp %h got %h", x.win, window_number); errors++;
                end
                if (byte_offset !== x.boff) begin
                    $error("byte_offset exp %h got %h", x.boff, byte_offset); errors++;
                end
                if (map_position !== x.mpos) begin
                    $error("map_position exp %h got %h", x.mpos, map_position); errors++;
                end
                if (last !== x.last) begin
                    $error("last exp %0d got %0d", x.last, last); errors++;
                end
            end
        end
        if (cycles > 200000) begin
            $display("block_window_refcount_cache test failed");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [47:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            bwrc_pkg::CFG_SCALE:  m_scale = val[12:0];
            bwrc_pkg::CFG_OFFSET: m_offset = val;
            bwrc_pkg::CFG_MOD:    m_mod = val[16:0];
            bwrc_pkg::CFG_SUBB:   m_subb = val[16:0];
            bwrc_pkg::CFG_UNIT:   m_unit = val[16:0];
            default:              m_park = val[4:0];
        endcase
    endtask

    task automatic run_phase(int sidle, int ridle);
        send_idle = sidle;
        recv_idle = ridle;
        sending = 1;
        wait (pending_reqs.size() == 0);
        @(posedge clk);
        sending = 0;
        wait (expected_results.size() == 0 && !push);
        repeat (200) @(posedge clk);
        recv_idle = 0;
    endtask

    function automatic void add_req(logic [1:0] k, logic [47:0] b);
        pending_reqs.push_back('{k, b});
    endfunction

    // mostly a small working set so hits, parks and evictions happen
    task automatic random_reqs(int n);
        logic [47:0] b;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 4)
                b = 48'({$urandom, $urandom});
            else
                b = 48'($urandom_range(40));
            if (r < 2)
                add_req(bwrc_pkg::REQ_NONE, b);
            else if (r < 8)
                add_req(bwrc_pkg::REQ_FLUSH, b);
            else if (r < 55)
                add_req(bwrc_pkg::REQ_ACCESS, b);
            else
                add_req(bwrc_pkg::REQ_RELEASE, b);
        end
    endtask

    initial begin
        m_scale = 1; m_offset = 0; m_mod = 1; m_subb = 512; m_unit = 512; m_park = 8;
        pq_cnt = 0;
        for (int i = 0; i < 16; i++)
        begin
            t_valid[i] = 0; t_win[i] = 0; t_refs[i] = 0; pq[i] = 0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // directed: defaults, empty flush, unknown, count error, full table
        add_req(bwrc_pkg::REQ_FLUSH, 0);
        add_req(bwrc_pkg::REQ_RELEASE, 48'd7);
        add_req(bwrc_pkg::REQ_ACCESS, 48'hFFFF_FFFF_FFFF);
        add_req(bwrc_pkg::REQ_RELEASE, 48'hFFFF_FFFF_FFFF);
        add_req(bwrc_pkg::REQ_RELEASE, 48'hFFFF_FFFF_FFFF);
        add_req(bwrc_pkg::REQ_NONE, 48'd3);
        for (int i = 0; i < 17; i++)
            add_req(bwrc_pkg::REQ_ACCESS, 48'(i));
        run_phase(0, 0);
        add_req(bwrc_pkg::REQ_RELEASE, 48'd2);
        add_req(bwrc_pkg::REQ_ACCESS, 48'd99);
        add_req(bwrc_pkg::REQ_FLUSH, 0);
        run_phase(0, 0);

        write_reg(bwrc_pkg::CFG_SCALE, 48'd4096);
        write_reg(bwrc_pkg::CFG_OFFSET, 48'hFFFF_FFFF_FFFF);
        write_reg(bwrc_pkg::CFG_MOD, 48'd65536);
        write_reg(bwrc_pkg::CFG_SUBB, 48'd65536);
        write_reg(bwrc_pkg::CFG_UNIT, 48'd65536);
        write_reg(bwrc_pkg::CFG_PARK, 48'd0);
        add_req(bwrc_pkg::REQ_ACCESS, 48'hFFFF_FFFF_FFFF);
        add_req(bwrc_pkg::REQ_RELEASE, 48'hFFFF_FFFF_FFFF);
        random_reqs(60);
        run_phase(53, 0);

        write_reg(bwrc_pkg::CFG_SCALE, 48'd3);
        write_reg(bwrc_pkg::CFG_OFFSET, 48'd5);
        write_reg(bwrc_pkg::CFG_MOD, 48'd0);
        write_reg(bwrc_pkg::CFG_PARK, 48'd16);
        random_reqs(60);
        run_phase(0, 53);

        write_reg(bwrc_pkg::CFG_MOD, 48'd7);
        write_reg(bwrc_pkg::CFG_SUBB, 48'd1);
        write_reg(bwrc_pkg::CFG_UNIT, 48'd1);
        write_reg(bwrc_pkg::CFG_PARK, 48'd31);
        random_reqs(60);
        run_phase(6, 6);

        write_reg(bwrc_pkg::CFG_SCALE, 48'd1);
        write_reg(bwrc_pkg::CFG_OFFSET, 48'd0);
        write_reg(bwrc_pkg::CFG_MOD, 48'd4);
        write_reg(bwrc_pkg::CFG_PARK, 48'd3);
        random_reqs(70);
        run_phase(0, 0);

        if (errors == 0)
            $display("block_window_refcount_cache test passed");
        else
            $display("block_window_refcount_cache test failed");
        $finish;
    end
endmodule
